// ===== design/ptd_pkg.sv =====
// Package for the programmable timer with divider.
// Holds the shared constants, the state record and the period mask lookup.
// No dependencies.
package ptd_pkg;

  // Cycles per divider step
  localparam int unsigned DIV_PERIOD = 256;

  // Divider accumulator width: at or above 256 it stays below DIV_PERIOD + 256,
  // below that it can climb to the 16-bit saturation point.
  localparam int unsigned DIV_ACC_W = (DIV_PERIOD >= 256) ? $clog2(DIV_PERIOD + 256) : 16;

  localparam int unsigned CNT_W      = 8;
  localparam int unsigned TMR_ACC_W  = 11;
  localparam int unsigned CTRL_W     = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TIMER_CONTROL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD_VALUE  = 1'd1;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [1:0] SEL_1024 = 2'd0;
  localparam logic [1:0] SEL_16   = 2'd1;
  localparam logic [1:0] SEL_64   = 2'd2;
  localparam logic [1:0] SEL_256  = 2'd3;

  localparam int unsigned CTRL_EN_BIT = 2;

  typedef struct packed {
    logic [CNT_W-1:0]     divider_count;
    logic [DIV_ACC_W-1:0] divider_accum;
    logic [CNT_W-1:0]     timer_count;
    logic [TMR_ACC_W-1:0] timer_accum;
  } ptd_state_t;

  // Period minus one; every period is a power of two
  function automatic logic [TMR_ACC_W-1:0] period_mask(input logic [1:0] sel);
    logic [TMR_ACC_W-1:0] m;
    unique case (sel)
      SEL_1024: m = TMR_ACC_W'(1023);
      SEL_16:   m = TMR_ACC_W'(15);
      SEL_64:   m = TMR_ACC_W'(63);
      SEL_256:  m = TMR_ACC_W'(255);
      default:  m = TMR_ACC_W'(1023);
    endcase
    return m;
  endfunction

endpackage

// ===== design/programmable_timer_with_divider.sv =====
// Top level of the programmable timer with divider.
// Depends on ptd_pkg and ptd_step.
//
// Each transfer is a tick carrying an elapsed count or a divider clear, and yields one
// result: divider counter, timer counter and a one-shot overflow flag. The update is
// one pass of adds and power-of-two masks between the state registers and the output
// register, so one item is accepted per cycle and its result appears the next cycle;
// the output register frees itself on the same edge it is taken, so a stalled consumer
// only blocks input while its result is still held. Registers are written through the
// cfg port at any time (index 0: timer control, index 1: reload value); unknown
// indices are ignored.
module programmable_timer_with_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [7:0]                        in_elapsed_cycles,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_divider_value,
  output logic [7:0]                        out_timer_value,
  output logic                              out_timer_interrupt,
  input  logic                              cfg_we,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  ptd_pkg::ptd_state_t                state_r, state_nxt;
  logic [ptd_pkg::CTRL_W-1:0]         ctrl_r;
  logic [ptd_pkg::CNT_W-1:0]          reload_r;
  logic                               out_valid_r;
  logic [7:0]                         div_out_r, tmr_out_r;
  logic                               irq_out_r;
  logic                               irq_nxt;
  logic                               in_acc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  ptd_step u_step (
    .cur      (state_r),
    .ctrl     (ctrl_r),
    .reload   (reload_r),
    .req_type (in_req_type),
    .elapsed  (in_elapsed_cycles),
    .nxt      (state_nxt),
    .irq      (irq_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      ctrl_r      <= '0;
      reload_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ptd_pkg::REG_TIMER_CONTROL: ctrl_r   <= cfg_wdata[ptd_pkg::CTRL_W-1:0];
          ptd_pkg::REG_RELOAD_VALUE:  reload_r <= cfg_wdata[ptd_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      div_out_r <= state_nxt.divider_count;
      tmr_out_r <= state_nxt.timer_count;
      irq_out_r <= irq_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_divider_value   = div_out_r;
  assign out_timer_value     = tmr_out_r;
  assign out_timer_interrupt = irq_out_r;

  // clear transfer zeroes the divider and never flags an overflow
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type == ptd_pkg::REQ_CLEAR
      |=> out_divider_value == 8'd0 && !out_timer_interrupt)
    else $error("clear transfer gave wrong result");

  // disabled timer holds its count and stays quiet
  a_timer_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !ctrl_r[ptd_pkg::CTRL_EN_BIT]
      |=> !out_timer_interrupt && out_timer_value == $past(state_r.timer_count))
    else $error("disabled timer moved");

  // with DIV_PERIOD at least 256, the divider accumulator never holds a full period after a step
  a_div_accum: assert property (@(posedge clk) disable iff (!rst_n)
    ptd_pkg::DIV_PERIOD >= 256
      |-> state_r.divider_accum < ptd_pkg::DIV_ACC_W'(ptd_pkg::DIV_PERIOD))
    else $error("divider accumulator out of range");

endmodule

// ===== design/ptd_step.sv =====
// Next-state logic for one transfer of the timer with divider.
// Pure combinational; depends on ptd_pkg.
module ptd_step (
  input  ptd_pkg::ptd_state_t                cur,
  input  logic [ptd_pkg::CTRL_W-1:0]         ctrl,
  input  logic [ptd_pkg::CNT_W-1:0]          reload,
  input  logic                               req_type,
  input  logic [7:0]                         elapsed,
  output ptd_pkg::ptd_state_t                nxt,
  output logic                               irq
);

  logic [ptd_pkg::DIV_ACC_W:0]     div_sum;
  logic [ptd_pkg::DIV_ACC_W-1:0]   div_sat;
  logic [ptd_pkg::TMR_ACC_W-1:0]   tmr_sum;
  logic [ptd_pkg::TMR_ACC_W-1:0]   tmr_mask;
  logic [ptd_pkg::CNT_W-1:0]       tmr_inc;

  always_comb begin
    nxt      = cur;
    irq      = 1'b0;
    div_sum  = {1'b0, cur.divider_accum} + (ptd_pkg::DIV_ACC_W + 1)'(elapsed);
    // saturate rather than wrap
    div_sat  = div_sum[ptd_pkg::DIV_ACC_W] ? {ptd_pkg::DIV_ACC_W{1'b1}}
                                            : div_sum[ptd_pkg::DIV_ACC_W-1:0];
    tmr_sum  = cur.timer_accum + ptd_pkg::TMR_ACC_W'(elapsed);
    tmr_mask = ptd_pkg::period_mask(ctrl[1:0]);
    tmr_inc  = cur.timer_count + ptd_pkg::CNT_W'(1);

    if (req_type == ptd_pkg::REQ_CLEAR) begin
      nxt.divider_count = '0;
    end else begin
      nxt.divider_accum = div_sat;
      if (div_sat >= ptd_pkg::DIV_ACC_W'(ptd_pkg::DIV_PERIOD)) begin
        nxt.divider_count = cur.divider_count + ptd_pkg::CNT_W'(1);
        nxt.divider_accum = div_sat - ptd_pkg::DIV_ACC_W'(ptd_pkg::DIV_PERIOD);
      end

      if (ctrl[ptd_pkg::CTRL_EN_BIT]) begin
        nxt.timer_accum = tmr_sum;
        // any bit above the mask means sum >= period
        if ((tmr_sum & ~tmr_mask) != '0) begin
          nxt.timer_accum = tmr_sum & tmr_mask;
          nxt.timer_count = tmr_inc;
          if (tmr_inc == '0) begin
            nxt.timer_count = reload;
            irq             = 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for programmable_timer_with_divider: directed table, then random phases.
// Depends on ptd_pkg and the design top; carries its own predictor of divider and timer.
module testbench;

  typedef struct packed {
    logic [7:0] divider;
    logic [7:0] timer;
    logic       irq;
  } timer_snapshot_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  // code is the request type for an item, the register index for a write
  typedef struct packed {
    row_kind_t       kind;
    logic            code;
    logic [7:0]      val;
    logic            typed;
    timer_snapshot_t want;
  } stim_row_t;

  localparam timer_snapshot_t UNTYPED = '0;
  localparam int unsigned ACC_CEIL = 65535;
  localparam int N_ROWS = 29;
  localparam int N_PHASES = 10;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_AT_RESULT = 500;
  localparam int HOLD_CYCLES = 300;

  localparam stim_row_t DIR_TABLE [N_ROWS] = '{
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd0,   1'b1, '{8'd0, 8'd0, 1'b0}},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd255, 1'b1, '{8'd0, 8'd0, 1'b0}},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd1,   1'b1, '{8'd1, 8'd0, 1'b0}},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd255, 1'b1, '{8'd1, 8'd0, 1'b0}},
    // accumulator well past one period: divider steps once only
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd255, 1'b1, '{8'd2, 8'd0, 1'b0}},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd255, 1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_CLEAR, 8'd0,   1'b1, '{8'd0, 8'd0, 1'b0}},
    '{ROW_ITEM,  ptd_pkg::REQ_CLEAR, 8'd255, 1'b1, '{8'd0, 8'd0, 1'b0}},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd3,   1'b0, UNTYPED},
    '{ROW_WRITE, ptd_pkg::REG_RELOAD_VALUE,  8'd254, 1'b0, UNTYPED},
    '{ROW_WRITE, ptd_pkg::REG_TIMER_CONTROL, 8'd4,   1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd255, 1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd255, 1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd255, 1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd255, 1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd4,   1'b0, UNTYPED},
    '{ROW_WRITE, ptd_pkg::REG_TIMER_CONTROL, 8'd5,   1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd0,   1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd15,  1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd1,   1'b0, UNTYPED},
    '{ROW_WRITE, ptd_pkg::REG_TIMER_CONTROL, 8'd4,   1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd200, 1'b0, UNTYPED},
    // shorter period with a stale accumulator above it
    '{ROW_WRITE, ptd_pkg::REG_TIMER_CONTROL, 8'd6,   1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd0,   1'b0, UNTYPED},
    // disabled: timer holds
    '{ROW_WRITE, ptd_pkg::REG_TIMER_CONTROL, 8'd3,   1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd255, 1'b0, UNTYPED},
    '{ROW_WRITE, ptd_pkg::REG_TIMER_CONTROL, 8'd7,   1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd255, 1'b0, UNTYPED},
    '{ROW_ITEM,  ptd_pkg::REQ_TICK,  8'd1,   1'b0, UNTYPED}
  };

  // control / reload pairs for the first random phases; later ones are drawn at random
  localparam logic [2:0] PHASE_CTL [6] = '{3'd5, 3'd5, 3'd7, 3'd6, 3'd0, 3'd5};
  localparam logic [7:0] PHASE_RELOAD [6] = '{8'd255, 8'd128, 8'd0, 8'd255, 8'd0, 8'd255};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_req_type;
  logic [7:0] in_elapsed_cycles;
  logic out_valid;
  logic out_ready;
  logic [7:0] out_divider_value;
  logic [7:0] out_timer_value;
  logic out_timer_interrupt;
  logic cfg_we;
  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ptd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // predictor state and register shadows
  logic [7:0] div_cnt;
  int unsigned div_acc;
  logic [7:0] tmr_cnt;
  int unsigned tmr_acc;
  logic [2:0] ctl_shadow;
  logic [7:0] reload_shadow;

  timer_snapshot_t pending_results[$];
  int mismatch_count = 0;
  int result_count = 0;
  bit steady = 1'b0;

  programmable_timer_with_divider i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_elapsed_cycles   (in_elapsed_cycles),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_divider_value   (out_divider_value),
    .out_timer_value     (out_timer_value),
    .out_timer_interrupt (out_timer_interrupt),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit gap_roll();
    return !steady && ($urandom_range(0, 99) < 21);
  endfunction

  function automatic timer_snapshot_t advance_timer(logic req, logic [7:0] n);
    timer_snapshot_t r;
    int unsigned per;
    logic irq;
    irq = 1'b0;
    per = 1024;
    if (req == ptd_pkg::REQ_CLEAR) begin
      div_cnt = '0;
    end else begin
      div_acc = div_acc + 32'(n);
      if (div_acc > ACC_CEIL) div_acc = ACC_CEIL;
      if (div_acc >= ptd_pkg::DIV_PERIOD) begin
        div_cnt = div_cnt + 8'd1;
        div_acc = div_acc - ptd_pkg::DIV_PERIOD;
      end
      if (ctl_shadow[ptd_pkg::CTRL_EN_BIT]) begin
        unique case (ctl_shadow[1:0])
          ptd_pkg::SEL_1024: per = 1024;
          ptd_pkg::SEL_16:   per = 16;
          ptd_pkg::SEL_64:   per = 64;
          ptd_pkg::SEL_256:  per = 256;
        endcase
        tmr_acc = tmr_acc + 32'(n);
        if (tmr_acc >= per) begin
          tmr_acc = tmr_acc & (per - 1);
          tmr_cnt = tmr_cnt + 8'd1;
          if (tmr_cnt == 8'd0) begin
            tmr_cnt = reload_shadow;
            irq = 1'b1;
          end
        end
      end
    end
    r.divider = div_cnt;
    r.timer = tmr_cnt;
    r.irq = irq;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_count < 10) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
  endtask

  // Offer one item, with a random gap first; returns on the edge of the transfer
  task automatic push_item(input logic req, input logic [7:0] n, input logic typed,
                           input timer_snapshot_t want);
    timer_snapshot_t predicted;
    while (gap_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_elapsed_cycles <= n;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = advance_timer(req, n);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input logic [ptd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] data);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ptd_pkg::REG_TIMER_CONTROL) ctl_shadow = data[2:0];
    else reload_shadow = data;
  endtask

  // Result side: random back-pressure outside the steady phase, plus one long hold-off to fill the block
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && result_count >= HOLD_AT_RESULT) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk) begin : result_check
    timer_snapshot_t want;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      result_count++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result div=%0d tmr=%0d irq=%0b",
                                out_divider_value, out_timer_value, out_timer_interrupt));
      end else begin
        want = pending_results.pop_front();
        if (out_divider_value !== want.divider)
          note_mismatch($sformatf("divider_value exp %0d got %0d", want.divider,
                                  out_divider_value));
        if (out_timer_value !== want.timer)
          note_mismatch($sformatf("timer_value exp %0d got %0d", want.timer,
                                  out_timer_value));
        if (out_timer_interrupt !== want.irq)
          note_mismatch($sformatf("timer_interrupt exp %0b got %0b", want.irq,
                                  out_timer_interrupt));
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [2:0] ctl;
    logic [7:0] rl;
    logic [4:0] pad;
    logic req;
    logic [7:0] n;
    int unsigned roll;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = ptd_pkg::REQ_TICK;
    in_elapsed_cycles = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    div_cnt = '0;
    div_acc = 0;
    tmr_cnt = '0;
    tmr_acc = 0;
    ctl_shadow = '0;
    reload_shadow = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].kind == ROW_WRITE)
        write_reg(DIR_TABLE[i].code, DIR_TABLE[i].val);
      else
        push_item(DIR_TABLE[i].code, DIR_TABLE[i].val, DIR_TABLE[i].typed,
                  DIR_TABLE[i].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 6) begin
        ctl = PHASE_CTL[p];
        rl = PHASE_RELOAD[p];
      end else begin
        ctl = 3'($urandom_range(0, 7));
        rl = 8'($urandom_range(0, 255));
      end
      pad = 5'($urandom_range(0, 31));
      // upper bits of the control write are don't-care in the block
      write_reg(ptd_pkg::REG_TIMER_CONTROL, {pad, ctl});
      write_reg(ptd_pkg::REG_RELOAD_VALUE, rl);
      steady = (p == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        req = (roll < 10) ? ptd_pkg::REQ_CLEAR : ptd_pkg::REQ_TICK;
        roll = $urandom_range(0, 99);
        if (roll < 40) n = 8'($urandom_range(0, 255));
        else if (roll < 70) n = 8'($urandom_range(0, 31));
        else n = 8'($urandom_range(224, 255));
        push_item(req, n, 1'b0, UNTYPED);
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    wait_drained();
    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
